>>> rtl/core/tssc_pkg.sv
// Shared types, codes and arithmetic helpers for the triple servo sweep controller.
`default_nettype none

package tssc_pkg;

	localparam int unsigned FIRST_SERVO_ID   = 3;
	localparam int unsigned ANGLE_AT_RESET   = 65;
	localparam int unsigned LOW_AT_RESET     = 65;
	localparam int unsigned HIGH_AT_RESET    = 180;
	localparam int unsigned SLOWEST_INTERVAL = 200;
	localparam int unsigned FASTEST_INTERVAL = 10;
	localparam int unsigned FULL_PERCENT     = 100;
	localparam int unsigned FULL_DUTY        = 255;
	localparam int unsigned SPAN             = SLOWEST_INTERVAL - FASTEST_INTERVAL;
	localparam int unsigned STOPPED_INTERVAL = SLOWEST_INTERVAL + SPAN / (FULL_PERCENT - 1);
	// floor(x / 99) == (x * 662) >> 16 for x up to 99 * 190
	localparam int unsigned RECIP_99         = 662;
	localparam int unsigned RECIP_99_SHIFT   = 16;
	// floor(x / 100) == (x * 10486) >> 20 for x up to 100 * 255
	localparam int unsigned RECIP_100        = 10486;
	localparam int unsigned RECIP_100_SHIFT  = 20;

	localparam int unsigned CFG_INDEX_W = 1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SWEEP_LOW  = 1'b0,
		REG_SWEEP_HIGH = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_SERVO = 2'd1,
		ACT_FAN   = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef struct packed {
		action_t    action;
		logic [6:0] servo_id;
		logic       run_flag;
		logic [6:0] speed_percent;
	} cmd_t;

	typedef struct packed {
		logic [7:0] first_position;
		logic [7:0] second_position;
		logic [7:0] third_position;
		logic [7:0] fan_duty;
		logic       bad_servo;
	} rsp_t;

	typedef struct packed {
		logic        tick;
		logic        load;
		logic        run;
		logic [7:0]  interval;
		logic [31:0] now;
		logic [7:0]  sweep_low;
		logic [7:0]  sweep_high;
	} servo_ctrl_t;

	function automatic logic [6:0] clamp_speed(input logic [6:0] s);
		return (s > 7'(FULL_PERCENT)) ? 7'(FULL_PERCENT) : s;
	endfunction

	function automatic logic [7:0] interval_of(input logic [6:0] speed);
		logic [14:0] x;
		logic [24:0] p;
		x = 15'((15'(speed) - 15'd1) * 15'(SPAN));
		p = 25'(x) * 25'(RECIP_99);
		if (speed == 7'd0)
			return 8'(STOPPED_INTERVAL);
		return 8'(9'(SLOWEST_INTERVAL) - p[RECIP_99_SHIFT+8:RECIP_99_SHIFT]);
	endfunction

	function automatic logic [7:0] duty_of(input logic [6:0] speed);
		logic [14:0] x;
		logic [28:0] p;
		x = 15'(speed) * 15'(FULL_DUTY);
		p = 29'(x) * 29'(RECIP_100);
		return p[RECIP_100_SHIFT+7:RECIP_100_SHIFT];
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/tssc_servo.sv
// One servo slice: run flag, interval, step timestamp and bouncing angle.
`default_nettype none

module tssc_servo (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tssc_pkg::servo_ctrl_t ctrl,
	output logic [7:0]                 angle_next
);
	import tssc_pkg::*;

	logic [31:0] last_q;
	logic [7:0]  angle_q;
	logic        up_q;
	logic        en_q;
	logic [7:0]  interval_q;

	logic [31:0] elapsed;
	logic        step;
	logic        up_next;

	assign elapsed = ctrl.now - last_q;
	assign step    = ctrl.tick && en_q && (elapsed >= {24'd0, interval_q});

	always_comb begin
		up_next = up_q;
		if (angle_q < ctrl.sweep_low)
			up_next = 1'b1;
		else if (angle_q > ctrl.sweep_high)
			up_next = 1'b0;
	end

	always_comb begin
		angle_next = angle_q;
		if (step)
			angle_next = up_next ? angle_q + 8'd1 : angle_q - 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= '0;
			angle_q    <= 8'(ANGLE_AT_RESET);
			up_q       <= 1'b1;
			en_q       <= 1'b0;
			interval_q <= '0;
		end else begin
			if (step) begin
				last_q  <= ctrl.now;
				angle_q <= angle_next;
				up_q    <= up_next;
			end
			if (ctrl.load) begin
				en_q       <= ctrl.run;
				interval_q <= ctrl.interval;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/triple_servo_sweep_controller.sv
// Top level of the triple servo sweep controller: command register, servo slices, fan duty.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one transaction per item: a
//   millisecond tick, a servo command (id, run flag, speed) or a fan command (speed).
//   rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one transaction per item
//   with the three servo angles, fan duty and the unknown-id flag, all after the item.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the sweep turning
//   points; cfg_ready is always high. Write it only while no item is in flight.
// Pipeline: an item is registered in the command register at acceptance, and its
//   result is registered in the result register, raising rsp_valid, once rsp is free.
// Throughput: one item per cycle unless rsp_stall holds a waiting result; the servo
//   slices, interval multiply and duty multiply sit between command and result register.
// Stall: while rsp_stall holds a waiting result, the registered command is held and
//   cmd_stall rises only once that command register is also occupied.
// Reset: angles 65 sweeping upward, servos stopped, intervals and fan duty zero,
//   millisecond count zero, turning points 65 and 180.
`default_nettype none

module triple_servo_sweep_controller #(
	parameter int SERVO_COUNT = 3
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     cmd_valid,
	output logic                                          cmd_stall,
	input  wire tssc_pkg::cmd_t                           cmd,
	output logic                                          rsp_valid,
	input  wire logic                                     rsp_stall,
	output tssc_pkg::rsp_t                                rsp,
	input  wire logic                                     cfg_valid,
	output logic                                          cfg_ready,
	input  wire logic [tssc_pkg::CFG_INDEX_W-1:0]         cfg_index,
	input  wire logic [7:0]                               cfg_data
);
	import tssc_pkg::*;

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic        advance;
	logic        rsp_valid_q;
	rsp_t        rsp_q;
	logic [7:0]  sweep_low_q;
	logic [7:0]  sweep_high_q;
	logic [31:0] ms_count_q;
	logic [7:0]  fan_q;

	logic [6:0]  speed;
	logic        is_tick;
	logic        is_servo;
	logic        id_ok;
	logic [7:0]  interval;
	logic [7:0]  fan_next;
	logic [31:0] now;
	rsp_t        rsp_next;

	logic [7:0]  angle_next [SERVO_COUNT];
	logic [7:0]  pos [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_low_q  <= 8'(LOW_AT_RESET);
			sweep_high_q <= 8'(HIGH_AT_RESET);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SWEEP_LOW:  sweep_low_q  <= cfg_data;
				REG_SWEEP_HIGH: sweep_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold the registered command while its result cannot leave
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign cmd_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (cmd_valid && !cmd_stall)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall)
			cmd_s1 <= cmd;
	end

	assign speed    = clamp_speed(cmd_s1.speed_percent);
	assign is_tick  = advance && (cmd_s1.action == ACT_TICK);
	assign is_servo = cmd_s1.action == ACT_SERVO;
	assign id_ok    = (cmd_s1.servo_id >= 7'(FIRST_SERVO_ID))
		&& ((cmd_s1.servo_id - 7'(FIRST_SERVO_ID)) < 7'(SERVO_COUNT));
	assign interval = interval_of(speed);
	assign fan_next = (cmd_s1.action == ACT_FAN) ? duty_of(speed) : fan_q;
	assign now      = ms_count_q + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_count_q <= '0;
			fan_q      <= '0;
		end else if (advance) begin
			if (cmd_s1.action == ACT_TICK)
				ms_count_q <= now;
			fan_q <= fan_next;
		end
	end

	for (genvar i = 0; i < SERVO_COUNT; i++) begin : g_servo
		servo_ctrl_t ctrl;
		assign ctrl.tick       = is_tick;
		assign ctrl.load       = advance && is_servo
			&& (cmd_s1.servo_id == 7'(FIRST_SERVO_ID + i));
		assign ctrl.run        = cmd_s1.run_flag;
		assign ctrl.interval   = interval;
		assign ctrl.now        = now;
		assign ctrl.sweep_low  = sweep_low_q;
		assign ctrl.sweep_high = sweep_high_q;

		tssc_servo u_servo (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.angle_next (angle_next[i])
		);
	end

	// servos that do not exist report zero
	for (genvar k = 0; k < 3; k++) begin : g_pos
		if (k < SERVO_COUNT) begin : g_live
			assign pos[k] = angle_next[k];
		end else begin : g_absent
			assign pos[k] = '0;
		end
	end

	always_comb begin
		rsp_next.first_position  = pos[0];
		rsp_next.second_position = pos[1];
		rsp_next.third_position  = pos[2];
		rsp_next.fan_duty        = fan_next;
		rsp_next.bad_servo       = is_servo && !id_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (advance)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			rsp_q <= rsp_next;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (valid_s1 && rsp_valid_q))
		else $error("command stalled without a held item and waiting result");

	a_advance_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("processed item produced no result");

	a_bad_only_servo: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (cmd_s1.action != ACT_SERVO)) |=> !rsp_q.bad_servo)
		else $error("unknown-id flag on a non-servo item");

	a_count_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && (cmd_s1.action == ACT_TICK)) |=> $stable(ms_count_q))
		else $error("millisecond count moved without a tick");

endmodule

`default_nettype wire
